@@ rtl/grnf_pkg.sv @@
// ----------------------------------------------------------------------------
// grnf_pkg
// Shared types and constants of the nearest-free grid placer.
// ----------------------------------------------------------------------------
package grnf_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int CELL_SHIFT  = 4;                      // 16-pixel cells
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = $clog2(MAX_COLS * MAX_ROWS);
    localparam int WORD_W      = 64;
    localparam int WIDX_W      = ADDR_W - $clog2(WORD_W);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int GRID_W      = 7;
    localparam int CAND_W      = 18;                     // candidate anchor, signed
    localparam int SPAN_W      = 20;                     // cell-space pixel offset

    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_PLACE  = 1'b1;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_AREA_LEFT   = 2'd2;
    localparam logic [1:0] CFG_AREA_TOP    = 2'd3;

    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_TOP    = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    typedef struct packed {
        logic clr_wr;      // zero one bitmap word
        logic load;        // capture input item
        logic cand;        // latch current candidate anchor
        logic calc;        // compute cell range, init cursor
        logic rd;          // read word under cursor
        logic step;        // advance cursor
        logic next;        // advance ring search
        logic restore;     // fall back to requested anchor
        logic set_found;
        logic set_marked;
        logic mk_wr;       // write back word with cursor bit set
        logic out_load;    // load result register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rng_ok;
        logic bit_set;
        logic cur_last;
        logic search_done;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/grid_rect_nearest_free_placer.sv @@
// ----------------------------------------------------------------------------
// grid_rect_nearest_free_placer
// Occupancy grid of 16-pixel cells with ring search for a free sprite spot.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tuser: op; tdata: anchor + extents
//  m_axis    out  tvalid/tready         tdata: placed anchor, found, marked
//  cfg       in   i_cfg_we (no stall)   i_cfg_idx, i_cfg_data
//
//  Reset runs a clearing pass over the bitmap (64 words of 64 bits)
//  with tready low; a clear item runs the same pass, then reports.
//  Place: each candidate passes range setup, then each cell is read and
//  checked until a busy cell; marking does a read-modify-write per cell
//  on the single bitmap port. Total depends on occupancy and ring
//  radius, bounded by the grid width.
//  One item is in work at a time; the result register frees the input
//  side while a finished result waits on m_axis.
// ----------------------------------------------------------------------------
module grid_rect_nearest_free_placer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,   // 0 grid_width, 1 grid_height, 2 area_left, 3 area_top
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] where_h, [31:16] where_v, [43:32] left_extent,
    // [55:44] width_extent, [67:56] top_extent, [79:68] height_extent
    input  logic [79:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser, // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] placed_h, [31:16] placed_v, [32] found, [33] marked, rest zero
    output logic [39:0] m_axis_tdata
);

    grnf_pkg::t_cmd cmd;
    grnf_pkg::t_sts sts;

    grnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    grnf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_op     (s_axis_tuser[0]),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

@@ rtl/grnf_ctrl.sv @@
// ----------------------------------------------------------------------------
// grnf_ctrl
// Sequencer for clearing, ring search over candidates and cell marking.
// ----------------------------------------------------------------------------
module grnf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    output logic           o_in_ready,
    input  grnf_pkg::t_sts i_sts,
    output grnf_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CAND  = 4'd2;
    localparam logic [3:0] S_CALC  = 4'd3;
    localparam logic [3:0] S_RCHK  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_MCALC = 4'd7;
    localparam logic [3:0] S_MRCHK = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_MWR   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_clr_item, n_clr_item;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_item = r_clr_item;
        o_cmd      = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_item ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_op == grnf_pkg::OP_CLEAR) begin
                        n_clr_item = 1'b1;
                        n_state    = S_CLR;
                    end else begin
                        n_state    = S_CAND;
                    end
                end
            end
            S_CAND: begin
                o_cmd.cand = 1'b1;
                n_state    = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_RCHK;
            end
            S_RCHK: begin
                if (i_sts.rng_ok) begin
                    n_state = S_RD;
                end else if (i_sts.search_done) begin
                    o_cmd.restore = 1'b1;
                    n_state       = S_MCALC;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_CAND;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.bit_set) begin
                    if (i_sts.search_done) begin
                        o_cmd.restore = 1'b1;
                        n_state       = S_MCALC;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_CAND;
                    end
                end else if (i_sts.cur_last) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_MCALC;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_MCALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MRCHK;
            end
            S_MRCHK: begin
                if (i_sts.rng_ok) begin
                    o_cmd.set_marked = 1'b1;
                    n_state          = S_MRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MWR;
            end
            S_MWR: begin
                o_cmd.mk_wr = 1'b1;
                if (i_sts.cur_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_MRD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_clr_item     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/grnf_dpath.sv @@
// ----------------------------------------------------------------------------
// grnf_dpath
// Config registers, search indices, cell range, occupancy bitmap, result.
// ----------------------------------------------------------------------------
module grnf_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_op,
    input  logic [79:0]    i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [39:0]    o_out_data,
    input  grnf_pkg::t_cmd i_cmd,
    output grnf_pkg::t_sts o_sts
);

    localparam int CW = grnf_pkg::CAND_W;
    localparam int SW = grnf_pkg::SPAN_W;
    localparam int CS = grnf_pkg::CELL_SHIFT;

    // configuration
    logic [grnf_pkg::GRID_W-1:0] r_gw, r_gh;
    logic signed [15:0]          r_area_l, r_area_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw     <= 7'd64;
            r_gh     <= 7'd64;
            r_area_l <= '0;
            r_area_t <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grnf_pkg::CFG_GRID_WIDTH:  r_gw     <= i_cfg_data[6:0];
                grnf_pkg::CFG_GRID_HEIGHT: r_gh     <= i_cfg_data[6:0];
                grnf_pkg::CFG_AREA_LEFT:   r_area_l <= i_cfg_data;
                grnf_pkg::CFG_AREA_TOP:    r_area_t <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [grnf_pkg::GRID_W-1:0] gw_eff, gh_eff;
    assign gw_eff = (r_gw > 7'(grnf_pkg::MAX_COLS)) ? 7'(grnf_pkg::MAX_COLS) : r_gw;
    assign gh_eff = (r_gh > 7'(grnf_pkg::MAX_ROWS)) ? 7'(grnf_pkg::MAX_ROWS) : r_gh;

    // captured item
    logic               r_op;
    logic signed [15:0] r_h0, r_v0;
    logic [11:0]        r_lext, r_wext, r_text, r_hext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_op;
            r_h0   <= i_in_data[15:0];
            r_v0   <= i_in_data[31:16];
            r_lext <= i_in_data[43:32];
            r_wext <= i_in_data[55:44];
            r_text <= i_in_data[67:56];
            r_hext <= i_in_data[79:68];
        end
    end

    // ring search indices
    logic                        r_first;
    logic [grnf_pkg::GRID_W-1:0] r_rad;
    logic signed [7:0]           r_idx;
    logic [1:0]                  r_side;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= 1'b1;
            r_rad   <= 7'd1;
            r_idx   <= -8'sd1;
            r_side  <= grnf_pkg::SIDE_LEFT;
        end else if (i_cmd.next) begin
            if (r_first) begin
                r_first <= 1'b0;
            end else if (r_side != grnf_pkg::SIDE_BOTTOM) begin
                r_side <= r_side + 2'd1;
            end else begin
                r_side <= grnf_pkg::SIDE_LEFT;
                if (r_idx < $signed({1'b0, r_rad})) begin
                    r_idx <= r_idx + 8'sd1;
                end else begin
                    r_rad <= r_rad + 7'd1;
                    r_idx <= -$signed({1'b0, r_rad + 7'd1});
                end
            end
        end
    end

    assign o_sts.search_done = r_first ? (gw_eff <= 7'd1)
                             : ((r_side == grnf_pkg::SIDE_BOTTOM)
                             && (r_idx == $signed({1'b0, r_rad}))
                             && ({1'b0, r_rad} + 8'd1 >= {1'b0, gw_eff}));

    // candidate anchor
    logic signed [CW-1:0] d_off, e_off, h0_x, v0_x, cand_h, cand_v;
    logic signed [CW-1:0] r_ch, r_cv;

    assign d_off = $signed({{(CW-grnf_pkg::GRID_W-CS){1'b0}}, r_rad, {CS{1'b0}}});
    assign e_off = $signed({{(CW-8-CS){r_idx[7]}}, r_idx, {CS{1'b0}}});
    assign h0_x  = CW'(r_h0);
    assign v0_x  = CW'(r_v0);

    always_comb begin
        cand_h = h0_x;
        cand_v = v0_x;
        if (!r_first) begin
            case (r_side)
                grnf_pkg::SIDE_LEFT:  begin cand_h = h0_x - d_off; cand_v = v0_x + e_off; end
                grnf_pkg::SIDE_RIGHT: begin cand_h = h0_x + d_off; cand_v = v0_x + e_off; end
                grnf_pkg::SIDE_TOP:   begin cand_h = h0_x + e_off; cand_v = v0_x - d_off; end
                default:              begin cand_h = h0_x + e_off; cand_v = v0_x + d_off; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand) begin
            r_ch <= cand_h;
            r_cv <= cand_v;
        end else if (i_cmd.restore) begin
            r_ch <= h0_x;
            r_cv <= v0_x;
        end
    end

    // cell range of the candidate rectangle
    logic signed [SW-1:0] x0, x1, y0, y1;
    logic                 fits, rng_ok_c;

    assign x0 = SW'(r_ch) - $signed({{(SW-12){1'b0}}, r_lext}) - SW'(r_area_l);
    assign x1 = x0 + $signed({{(SW-12){1'b0}}, r_wext});
    assign y0 = SW'(r_cv) - $signed({{(SW-12){1'b0}}, r_text}) - SW'(r_area_t);
    assign y1 = y0 + $signed({{(SW-12){1'b0}}, r_hext});
    assign fits = (r_ch[CW-1:15] == '0 || r_ch[CW-1:15] == '1)
               && (r_cv[CW-1:15] == '0 || r_cv[CW-1:15] == '1);
    // x0 >= one cell means column 0 excluded; then x1 is non-negative too
    assign rng_ok_c = fits
        && (x0 >= $signed(SW'(1 << CS))) && (y0 >= $signed(SW'(1 << CS)))
        && (x1[SW-1:CS] < (SW-CS)'(gw_eff)) && (y1[SW-1:CS] < (SW-CS)'(gh_eff));

    logic                            r_rng_ok;
    logic [grnf_pkg::COL_W-1:0]      r_c0, r_c1, r_col;
    logic [grnf_pkg::ROW_W-1:0]      r_r1, r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_rng_ok <= rng_ok_c;
            r_c0     <= x0[CS +: grnf_pkg::COL_W];
            r_col    <= x0[CS +: grnf_pkg::COL_W];
            r_c1     <= x1[CS +: grnf_pkg::COL_W];
            r_row    <= y0[CS +: grnf_pkg::ROW_W];
            r_r1     <= y1[CS +: grnf_pkg::ROW_W];
        end else if (i_cmd.step) begin
            if (r_col == r_c1) begin
                r_col <= r_c0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_sts.rng_ok   = r_rng_ok;
    assign o_sts.cur_last = (r_col == r_c1) && (r_row == r_r1);

    // occupancy bitmap, 64-bit words, flat address row * stride + column
    logic [grnf_pkg::WORD_W-1:0] mem [2**grnf_pkg::WIDX_W];
    logic [grnf_pkg::WORD_W-1:0] r_rd_word;
    logic [grnf_pkg::WIDX_W-1:0] r_widx, r_clr_cnt;
    logic [grnf_pkg::BIT_W-1:0]  r_bit;
    logic [12:0]                 addr_c;

    assign addr_c = {7'd0, r_row} * {6'd0, gw_eff} + {7'd0, r_col};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_word <= mem[addr_c[grnf_pkg::ADDR_W-1:grnf_pkg::BIT_W]];
            r_widx    <= addr_c[grnf_pkg::ADDR_W-1:grnf_pkg::BIT_W];
            r_bit     <= addr_c[grnf_pkg::BIT_W-1:0];
        end
        if (i_cmd.clr_wr) begin
            mem[r_clr_cnt] <= '0;
        end else if (i_cmd.mk_wr) begin
            mem[r_widx] <= r_rd_word | (grnf_pkg::WORD_W'(1) << r_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == '1);
    assign o_sts.bit_set  = r_rd_word[r_bit];

    // result flags and output register
    logic r_found, r_marked, r_out_valid;
    logic [39:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found  <= 1'b0;
            r_marked <= 1'b0;
        end else begin
            if (i_cmd.set_found)  r_found  <= 1'b1;
            if (i_cmd.set_marked) r_marked <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_op == grnf_pkg::OP_CLEAR) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {6'd0, r_marked, r_found, r_cv[15:0], r_ch[15:0]};
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

@@ rtl/grnf_checker.sv @@
// ----------------------------------------------------------------------------
// grnf_checker
// Port-level checks of the placer, bound to the top level.
// ----------------------------------------------------------------------------
module grnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // clearing pass follows reset
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during reset clearing pass");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // a new result only comes out of a busy sequencer
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without work in progress");

endmodule

bind grid_rect_nearest_free_placer grnf_checker u_grnf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
